### design/edd_pkg.sv
`default_nettype none

package edd_pkg;

  localparam int BYTE_W      = 8;
  localparam int RESULT_W    = 32;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] code;
    logic              zero_byte;
  } code_item_t;

  typedef struct packed {
    logic       valid;
    code_item_t item;
  } queue_head_t;

endpackage

`default_nettype wire

### design/elias_delta_decoder_top.sv
// Elias delta decoder.
// Input channel: code_byte with code_valid/code_stall. A transaction moves one
// byte of the packed code stream, read most significant bit first.
// Output channel: decoded_value and last_of_byte with result_valid/result_stall.
// Each transaction carries one decoded number n (code word value n+1);
// last_of_byte marks the final number produced by an input byte.
// Bytes enter a 4-entry queue, at most one per cycle while it is not full; the
// decoder walks one bit per cycle unless a held result stalls it, except an
// all-zero byte that reaches an idle decoder while it counts leading zeros,
// which it consumes whole. Sustained rate is set by that bit-serial loop.
// An earlier result of a byte is presented at the edge that decodes the byte's
// next result; the last result is flagged final in the hold at the edge that
// decodes the byte's last bit and is presented once the output is free.
// Reset clears the queue, the decoder state and the output valid flag.
// A stalled result holds; while it stalls and another result waits in the
// one-deep hold, the decoder stops and the queue absorbs input until it fills.
`default_nettype none

module elias_delta_decoder_top #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [edd_pkg::BYTE_W-1:0]       code_byte,
  input  wire logic                             code_valid,
  output logic                                  code_stall,
  output logic [edd_pkg::RESULT_W-1:0]          decoded_value,
  output logic                                  last_of_byte,
  output logic                                  result_valid,
  input  wire logic                             result_stall
);

  edd_pkg::queue_head_t head;
  logic                 take;

  edd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .code_byte  (code_byte),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .head       (head),
    .take       (take)
  );

  edd_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .take          (take),
    .decoded_value (decoded_value),
    .last_of_byte  (last_of_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall)
  );

endmodule

`default_nettype wire

### design/edd_front.sv
`default_nettype none

module edd_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [edd_pkg::BYTE_W-1:0] code_byte,
  input  wire logic                       code_valid,
  output logic                            code_stall,
  output edd_pkg::queue_head_t            head,
  input  wire logic                       take
);

  edd_pkg::code_item_t queue [edd_pkg::QUEUE_DEPTH];
  logic [edd_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [edd_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [edd_pkg::QUEUE_AW:0]   count;
  logic                         push;
  logic                         pop;

  assign code_stall = (count == (edd_pkg::QUEUE_AW+1)'(edd_pkg::QUEUE_DEPTH));
  assign push       = code_valid && !code_stall;
  assign pop        = take && head.valid;

  assign head.valid = (count != '0);
  assign head.item  = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr].code      <= code_byte;
      queue[wr_ptr].zero_byte <= (code_byte == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= (edd_pkg::QUEUE_AW+1)'(edd_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk) disable iff (rst)
    take |-> head.valid)
    else $error("take from empty queue");

endmodule

`default_nettype wire

### design/edd_back.sv
`default_nettype none

module edd_back #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire edd_pkg::queue_head_t             head,
  output logic                                  take,
  output logic [edd_pkg::RESULT_W-1:0]          decoded_value,
  output logic                                  last_of_byte,
  output logic                                  result_valid,
  input  wire logic                             result_stall
);

  localparam logic [1:0] PH_ZEROS  = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;

  logic [1:0]                   phase, phase_next;
  logic [VALUE_BITS-1:0]        zero_count, zero_count_next;
  logic [VALUE_BITS-1:0]        length_left, length_left_next;
  logic [VALUE_BITS-1:0]        value_acc, value_acc_next;
  logic [edd_pkg::BYTE_W-1:0]   cur;
  logic [2:0]                   bit_idx;
  logic                         busy;
  logic                         pend_valid;
  logic                         pend_final;
  logic [edd_pkg::RESULT_W-1:0] pend_value;

  logic                         bit_in;
  logic                         last_bit;
  logic                         out_free;
  logic                         step;
  logic                         step_last;
  logic                         fast;
  logic                         emit;
  logic                         push;
  logic [VALUE_BITS-1:0]        res_w;
  logic [edd_pkg::RESULT_W-1:0] res32;
  logic [VALUE_BITS-1:0]        zc_dec;
  logic [VALUE_BITS-1:0]        ll_dec;
  logic [VALUE_BITS-1:0]        ll_shift;
  logic [VALUE_BITS-1:0]        ll_shift_dec;
  logic [VALUE_BITS-1:0]        va_shift;
  logic [VALUE_BITS-1:0]        va_dec;

  assign bit_in    = cur[edd_pkg::BYTE_W-1];
  assign last_bit  = (bit_idx == 3'd7);
  assign out_free  = !result_valid || !result_stall;
  assign step      = busy && (!pend_valid || out_free);
  assign step_last = step && last_bit;
  // all-zero byte while idle and counting zeros: consume it whole without walking its bits
  assign fast      = head.valid && !busy && (phase == PH_ZEROS) && head.item.zero_byte;
  assign take      = head.valid && (!busy || step_last);
  assign push      = out_free && pend_valid && ((step && emit) || pend_final);

  assign zc_dec       = zero_count - VALUE_BITS'(1);
  assign ll_dec       = length_left - VALUE_BITS'(1);
  assign ll_shift     = {length_left[VALUE_BITS-2:0], bit_in};
  assign ll_shift_dec = ll_shift - VALUE_BITS'(1);
  assign va_shift     = {value_acc[VALUE_BITS-2:0], bit_in};
  assign va_dec       = va_shift - VALUE_BITS'(1);

  generate
    if (VALUE_BITS >= edd_pkg::RESULT_W) begin : g_trunc
      assign res32 = res_w[edd_pkg::RESULT_W-1:0];
    end else begin : g_ext
      assign res32 = {{(edd_pkg::RESULT_W-VALUE_BITS){1'b0}}, res_w};
    end
  endgenerate

  always_comb begin
    phase_next       = phase;
    zero_count_next  = zero_count;
    length_left_next = length_left;
    value_acc_next   = value_acc;
    emit             = 1'b0;
    res_w            = '0;
    if (step) begin
      case (phase)
        PH_ZEROS: begin
          if (!bit_in) begin
            zero_count_next = zero_count + VALUE_BITS'(1);
          end else if (zero_count == '0) begin
            emit = 1'b1;
          end else begin
            phase_next       = PH_LENGTH;
            length_left_next = VALUE_BITS'(1);
          end
        end
        PH_LENGTH: begin
          zero_count_next = zc_dec;
          if (zc_dec == '0) begin
            phase_next       = PH_VALUE;
            value_acc_next   = VALUE_BITS'(1);
            length_left_next = ll_shift_dec;
          end else begin
            length_left_next = ll_shift;
          end
        end
        default: begin
          length_left_next = ll_dec;
          value_acc_next   = va_shift;
          if (ll_dec == '0) begin
            emit       = 1'b1;
            res_w      = va_dec;
            phase_next = PH_ZEROS;
          end
        end
      endcase
    end else if (fast) begin
      zero_count_next = zero_count + VALUE_BITS'(8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_ZEROS;
      zero_count  <= '0;
      length_left <= '0;
      value_acc   <= '0;
    end else begin
      phase       <= phase_next;
      zero_count  <= zero_count_next;
      length_left <= length_left_next;
      value_acc   <= value_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      bit_idx <= '0;
    end else if (take && !fast) begin
      busy    <= 1'b1;
      bit_idx <= '0;
      cur     <= head.item.code;
    end else if (step) begin
      cur     <= {cur[edd_pkg::BYTE_W-2:0], 1'b0};
      bit_idx <= bit_idx + 3'd1;
      if (last_bit) busy <= 1'b0;
    end
  end

  // one-deep hold so the final result of a byte can be flagged
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      pend_final <= 1'b0;
    end else if (step && emit) begin
      pend_valid <= 1'b1;
      pend_final <= last_bit;
      pend_value <= res32;
    end else if (push) begin
      pend_valid <= 1'b0;
      pend_final <= 1'b0;
    end else if (step_last && pend_valid) begin
      pend_final <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid  <= 1'b1;
      decoded_value <= pend_value;
      last_of_byte  <= pend_final;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    pend_final |-> pend_valid)
    else $error("final flag without held result");

  assert property (@(posedge clk) disable iff (rst)
    (step && emit && pend_valid) |-> push)
    else $error("held result overwritten");

  assert property (@(posedge clk) disable iff (rst)
    (step && !last_bit) |=> busy)
    else $error("byte dropped before its last bit");

  assert property (@(posedge clk) disable iff (rst)
    fast |-> (!busy && !step))
    else $error("zero byte shortcut while busy");

endmodule

`default_nettype wire

### tb/elias_delta_decoder_top_tb.sv
`default_nettype none

module elias_delta_decoder_top_tb;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_BYTES = 420;

  localparam logic [1:0] PH_ZEROS  = 2'd0;
  localparam logic [1:0] PH_LENGTH = 2'd1;
  localparam logic [1:0] PH_VALUE  = 2'd2;

  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] zeros;
    logic [31:0] len;
    logic [31:0] acc;
  } delta_state_t;

  typedef struct packed {
    logic [edd_pkg::RESULT_W-1:0] value;
    logic                         is_last;
  } decoded_t;

  logic                         clk;
  logic                         rst = 1'b1;
  logic [edd_pkg::BYTE_W-1:0]   code_byte = '0;
  logic                         code_valid = 1'b0;
  logic                         code_stall;
  logic [edd_pkg::RESULT_W-1:0] decoded_value;
  logic                         last_of_byte;
  logic                         result_valid;
  logic                         result_stall = 1'b0;

  logic [edd_pkg::BYTE_W-1:0] pending_bytes[$];
  decoded_t          expected_numbers[$];
  delta_state_t      decoder_model = '0;
  delta_state_t      stream_model = '0;
  logic [7:0]        pack_buf = '0;
  int                pack_cnt = 0;
  int                gen_bytes = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                send_gap = 0;
  int                hold_cycles = 0;
  bit                byte_taken = 1'b0;
  bit                result_taken = 1'b0;

  elias_delta_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .code_byte    (code_byte),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .decoded_value(decoded_value),
    .last_of_byte (last_of_byte),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One bit through the delta decoding machine.
  function automatic void walk_bit(input delta_state_t s, input bit b,
                                   output delta_state_t n, output bit done,
                                   output logic [31:0] num);
    n = s;
    done = 1'b0;
    num = '0;
    if (s.phase == PH_ZEROS) begin
      if (!b) begin
        n.zeros = s.zeros + 32'd1;
      end else if (s.zeros == 32'd0) begin
        done = 1'b1;
      end else begin
        n.phase = PH_LENGTH;
        n.len = 32'd1;
      end
    end else if (s.phase == PH_LENGTH) begin
      n.zeros = s.zeros - 32'd1;
      n.len = {s.len[30:0], b};
      if (n.zeros == 32'd0) begin
        n.phase = PH_VALUE;
        n.acc = 32'd1;
        n.len = n.len - 32'd1;
      end
    end else begin
      n.len = s.len - 32'd1;
      n.acc = {s.acc[30:0], b};
      if (n.len == 32'd0) begin
        done = 1'b1;
        num = n.acc - 32'd1;
        n.phase = PH_ZEROS;
      end
    end
  endfunction

  task automatic expect_from_byte(input logic [edd_pkg::BYTE_W-1:0] b);
    delta_state_t nxt;
    bit           done;
    logic [31:0]  num;
    decoded_t     found[$];
    for (int k = edd_pkg::BYTE_W - 1; k >= 0; k--) begin
      walk_bit(decoder_model, b[k], nxt, done, num);
      decoder_model = nxt;
      if (done) found.push_back('{value: num, is_last: 1'b0});
    end
    for (int k = 0; k < found.size(); k++) begin
      if (k == found.size() - 1) found[k].is_last = 1'b1;
      expected_numbers.push_back(found[k]);
    end
  endtask

  function automatic int draw_wait();
    if (cycle_count % 600 < 150) return 0;
    return $urandom_range(0, 4);
  endfunction

  // Stream builder: every bit also runs through a shadow decoder so that
  // codes can always be started from a clean state.
  task automatic push_bit(input bit b);
    delta_state_t nxt;
    bit           done;
    logic [31:0]  num;
    walk_bit(stream_model, b, nxt, done, num);
    stream_model = nxt;
    pack_buf = {pack_buf[6:0], b};
    pack_cnt++;
    if (pack_cnt == 8) begin
      pending_bytes.push_back(pack_buf);
      gen_bytes++;
      pack_cnt = 0;
    end
  endtask

  task automatic put_bits(input logic [32:0] v, input int cnt);
    for (int i = cnt - 1; i >= 0; i--) push_bit(v[i]);
  endtask

  task automatic resync();
    while (!(stream_model.phase == PH_ZEROS && stream_model.zeros == 32'd0)) begin
      if (stream_model.phase == PH_ZEROS) push_bit(1'b1);
      else if (stream_model.phase == PH_LENGTH) push_bit(1'b0);
      else push_bit(1'($urandom_range(0, 1)));
    end
  endtask

  task automatic align();
    resync();
    while (pack_cnt != 0) push_bit(1'b1);
  endtask

  task automatic put_code(input logic [31:0] n);
    logic [32:0] big;
    int          len_bits;
    int          len_len;
    big = {1'b0, n} + 33'd1;
    len_bits = 33;
    while (!big[len_bits-1]) len_bits--;
    len_len = 6;
    while (((len_bits >> (len_len - 1)) & 1) == 0) len_len--;
    if (len_bits == 1) begin
      push_bit(1'b1);
    end else begin
      repeat (len_len - 1) push_bit(1'b0);
      put_bits(33'(len_bits), len_len);
      put_bits(big, len_bits - 1);
    end
  endtask

  task automatic put_noise(input int cnt);
    logic [7:0]   b;
    delta_state_t trial;
    delta_state_t nxt;
    bit           done;
    logic [31:0]  num;
    repeat (cnt) begin
      do begin
        b = 8'($urandom_range(0, 255));
        trial = stream_model;
        for (int k = 7; k >= 0; k--) begin
          walk_bit(trial, b[k], nxt, done, num);
          trial = nxt;
        end
      end while (trial.zeros > 32'd5 || (trial.phase >= PH_VALUE && trial.len > 32'd64));
      put_bits({25'd0, b}, 8);
    end
    resync();
  endtask

  // Zero byte while counting zeros, then a 9-bit length field.
  task automatic put_zero_byte_code();
    align();
    put_bits(33'd0, 8);
    push_bit(1'b1);
    put_bits(33'($urandom_range(0, 15)), 8);
    resync();
  endtask

  // 32 leading zeros: the length field wraps to its low 32 bits.
  task automatic put_wrapped_length(input logic [31:0] wrapped_len);
    align();
    put_bits(33'd0, 32);
    push_bit(1'b1);
    put_bits({1'b0, wrapped_len}, 32);
    resync();
  endtask

  task automatic put_random_codes(input int target);
    int          pick;
    int          w;
    logic [31:0] n;
    while (gen_bytes < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        w = $urandom_range(0, 32);
        n = $urandom;
        if (w < 32) n = n & ((32'd1 << w) - 32'd1);
        if ($urandom_range(0, 30) == 0) n = 32'hFFFF_FFFF;
        put_code(n);
      end else if (pick < 88) begin
        put_noise($urandom_range(1, 3));
      end else if (pick < 94) begin
        align();
        repeat ($urandom_range(8, 24)) put_code(32'd0);
      end else if (pick < 97) begin
        put_zero_byte_code();
      end else begin
        put_wrapped_length($urandom_range(2, 40));
      end
    end
  endtask

  task automatic wait_idle();
    while (!(pending_bytes.size() == 0 && !code_valid && expected_numbers.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst) begin
      if (code_valid && !byte_taken) begin
      end else if (send_gap > 0) begin
        code_valid <= 1'b0;
        send_gap = send_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        code_byte <= pending_bytes.pop_front();
        code_valid <= 1'b1;
        send_gap = draw_wait();
      end else begin
        code_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (result_taken) hold_cycles = draw_wait();
      if (result_valid && hold_cycles > 0) begin
        result_stall <= 1'b1;
        hold_cycles = hold_cycles - 1;
      end else if (!result_valid && cycle_count % 600 >= 150) begin
        result_stall <= ($urandom_range(0, 7) == 0);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    decoded_t exp;
    byte_taken = 1'b0;
    result_taken = 1'b0;
    if (!rst) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("Verification failed");
        $finish;
      end else begin
        if (code_valid && !code_stall) begin
          byte_taken = 1'b1;
          expect_from_byte(code_byte);
        end
        if (result_valid && !result_stall) begin
          result_taken = 1'b1;
          if (expected_numbers.size() == 0) begin
            $display("%0t: unexpected transaction: expected none, actual value %h last %b",
                     $time, decoded_value, last_of_byte);
            mismatch_count++;
          end else begin
            exp = expected_numbers.pop_front();
            if (decoded_value !== exp.value) begin
              $display("%0t: decoded_value: expected %h, actual %h",
                       $time, exp.value, decoded_value);
              mismatch_count++;
            end
            if (last_of_byte !== exp.is_last) begin
              $display("%0t: last_of_byte: expected %b, actual %b",
                       $time, exp.is_last, last_of_byte);
              mismatch_count++;
            end
          end
        end
      end
    end
  end

  initial begin
    int start;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    repeat (8) put_code(32'd0);
    put_code(32'd1);
    put_code(32'd2);
    put_code(32'd3);
    put_code(32'hFFFF_FFFF);
    put_code(32'hFFFF_FFFE);
    put_code(32'h8000_0000);
    put_wrapped_length(32'd5);
    align();
    wait_idle();

    start = gen_bytes;
    put_random_codes(start + RANDOM_BYTES / 2);
    align();
    wait_idle();

    put_random_codes(start + RANDOM_BYTES);
    resync();
    while (pack_cnt != 0) push_bit(1'b0);
    put_bits(33'd0, 8);
    wait_idle();

    if (expected_numbers.size() != 0)
      $display("%0t: %0d expected transactions never arrived", $time, expected_numbers.size());
    if (mismatch_count == 0 && expected_numbers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/edd_pkg.sv
design/edd_front.sv
design/edd_back.sv
design/elias_delta_decoder_top.sv
tb/elias_delta_decoder_top_tb.sv
